### design/spc_pkg.sv
// Shared types and constants for the skeleton pixel classifier.
package spc_pkg;

  // Default frame limits
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  // Configuration port
  localparam int CFG_W  = 12;
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]  RST_IMAGE_WIDTH  = 12'd1388;
  localparam logic [CFG_W-1:0]  RST_IMAGE_HEIGHT = 12'd1026;

  // Result field widths
  localparam int POS_W  = 11;
  localparam int DEG_W  = 3;
  localparam int KIND_W = 2;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 3;

  // Pixel kinds
  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENDPOINT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_JUNCTION = 2'd2;

  // 3x3 window, bit r*3+c; masks of the border rows and columns
  localparam logic [8:0] WIN_TOP    = 9'h007;
  localparam logic [8:0] WIN_BOTTOM = 9'h1C0;
  localparam logic [8:0] WIN_LEFT   = 9'h049;
  localparam logic [8:0] WIN_RIGHT  = 9'h124;
  localparam logic [8:0] WIN_CENTRE = 9'h010;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CNT_W = 3;

  // One classified-window entry
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [8:0]       win;
  } spc_item_t;

  // Front to queue
  typedef struct packed {
    logic      push;
    spc_item_t item;
  } spc_push_t;

  // Queue status toward front and back
  typedef struct packed {
    logic [Q_CNT_W-1:0] level;
    logic               nonempty;
  } spc_qstat_t;

endpackage

### design/spc_front.sv
// Front end: raster counters, line stores, 3x3 window and border masking.
module spc_front import spc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_pixel,
  input  spc_qstat_t        qstat,
  output spc_push_t         push_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int DW    = $clog2(MAX_WIDTH + 1);
  localparam int DH    = $clog2(MAX_HEIGHT + 1);
  localparam int WCW   = (CFG_W > DW) ? CFG_W : DW;
  localparam int HCW   = (CFG_W > DH) ? CFG_W : DH;

  // Configuration registers
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to [3, max]
  logic [WCW-1:0] wcfg;
  logic [HCW-1:0] hcfg;
  logic [DW-1:0]  eff_w;
  logic [DH-1:0]  eff_h;

  always_comb begin
    wcfg = WCW'(width_r);
    hcfg = HCW'(height_r);
    if (wcfg < WCW'(3))              eff_w = DW'(3);
    else if (wcfg > WCW'(MAX_WIDTH)) eff_w = DW'(MAX_WIDTH);
    else                             eff_w = DW'(wcfg);
    if (hcfg < HCW'(3))               eff_h = DH'(3);
    else if (hcfg > HCW'(MAX_HEIGHT)) eff_h = DH'(MAX_HEIGHT);
    else                              eff_h = DH'(hcfg);
  end

  // Control state
  logic             clr_active_r;
  logic [COL_W-1:0] clr_addr_r;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic             s1_valid_r;
  logic             accept;

  assign in_tready = !clr_active_r &&
                     ((qstat.level + Q_CNT_W'(s1_valid_r)) < Q_CNT_W'(Q_DEPTH));
  assign accept    = in_tvalid && in_tready;

  // Stage 0: position, centre location and border mask
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row, h_row, crow;
  logic [COL_W-1:0] ccol, wlast;
  logic [DW-1:0]    col_inc;
  logic             pix, col_nz, cvalid;
  logic [8:0]       keep;

  always_comb begin
    row    = in_row_r;
    h_row  = ROW_W'(eff_h);
    wlast  = COL_W'(eff_w - DW'(1));
    col    = (DW'(in_col_r) >= eff_w) ? '0 : in_col_r;
    col    = col & COL_W'(MAX_WIDTH - 1);
    pix    = (row < h_row) && in_pixel;
    col_nz = (col != '0);
    if (col_nz) begin
      crow   = row - ROW_W'(1);
      ccol   = col - COL_W'(1);
      cvalid = (row >= ROW_W'(1)) && (row <= h_row);
    end else begin
      crow   = row - ROW_W'(2);
      ccol   = wlast;
      cvalid = (row >= ROW_W'(2)) && (row <= h_row + ROW_W'(1));
    end
    keep = 9'h1FF;
    if (crow == '0)                  keep = keep & ~WIN_TOP;
    if (crow == h_row - ROW_W'(1))   keep = keep & ~WIN_BOTTOM;
    if (ccol == '0)                  keep = keep & ~WIN_LEFT;
    if (ccol == wlast)               keep = keep & ~WIN_RIGHT;
    // raster counters
    col_inc = DW'(col) + DW'(1);
    if (row >= h_row + ROW_W'(1)) begin
      in_row_nxt = '0;
      in_col_nxt = '0;
    end else if (col_inc >= eff_w) begin
      in_row_nxt = row + ROW_W'(1);
      in_col_nxt = '0;
    end else begin
      in_row_nxt = row;
      in_col_nxt = COL_W'(col_inc);
    end
  end

  // Stage 1 registers
  logic [COL_W-1:0] s1_col_r;
  logic             s1_pix_r;
  logic             s1_cvalid_r;
  logic [POS_W-1:0] s1_row_r;
  logic [POS_W-1:0] s1_ccol_r;
  logic [8:0]       s1_keep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      in_row_r     <= '0;
      in_col_r     <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + COL_W'(1);
        if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) clr_active_r <= 1'b0;
      end
      if (accept) begin
        in_row_r <= in_row_nxt;
        in_col_r <= in_col_nxt;
      end
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r    <= col;
      s1_pix_r    <= pix;
      s1_cvalid_r <= cvalid;
      s1_row_r    <= POS_W'(crow);
      s1_ccol_r   <= POS_W'(ccol);
      s1_keep_r   <= keep;
    end
  end

  // Line stores: bit 1 upper row, bit 0 middle row; the write follows the read in the next cycle
  logic [1:0]       line_mem [MAX_WIDTH];
  logic [1:0]       rd_r;
  logic [1:0]       fwd_data_r;
  logic             fwd_hit_r;
  logic [1:0]       rd_eff;
  logic             mem_we;
  logic [COL_W-1:0] mem_waddr;
  logic [1:0]       mem_wdata;

  assign rd_eff    = fwd_hit_r ? fwd_data_r : rd_r;
  assign mem_we    = clr_active_r || s1_valid_r;
  assign mem_waddr = clr_active_r ? clr_addr_r : s1_col_r;
  assign mem_wdata = clr_active_r ? 2'b00 : {rd_eff[0], s1_pix_r};

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[mem_waddr] <= mem_wdata;
    if (accept) begin
      rd_r       <= line_mem[col];
      // catch a read of the column being written back this cycle
      fwd_hit_r  <= s1_valid_r && (s1_col_r == col);
      fwd_data_r <= mem_wdata;
    end
  end

  // Sliding window
  logic [8:0] win_r, win_nxt;

  always_comb begin
    win_nxt    = {win_r[8:7], 1'b0, win_r[5:4], 1'b0, win_r[2:1], 1'b0} >> 1;
    win_nxt    = {1'b0, win_r[8:7], 1'b0, win_r[5:4], 1'b0, win_r[2:1]};
    win_nxt[2] = rd_eff[1];
    win_nxt[5] = rd_eff[0];
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  // Push the masked window toward the back end
  always_comb begin
    push_o.push       = s1_valid_r;
    push_o.item.valid = s1_cvalid_r;
    push_o.item.row   = s1_row_r;
    push_o.item.col   = s1_ccol_r;
    push_o.item.win   = win_nxt & s1_keep_r;
  end

endmodule

### design/spc_queue.sv
// Short queue between the front end and the back end.
module spc_queue import spc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  spc_push_t  push_i,
  input  logic       pop,
  output spc_item_t  head,
  output spc_qstat_t qstat
);

  spc_item_t          entry_r [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr_r;
  logic [Q_AW-1:0]    rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i.push) wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      if (pop)         rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      if (push_i.push && !pop)      count_r <= count_r + Q_CNT_W'(1);
      else if (!push_i.push && pop) count_r <= count_r - Q_CNT_W'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push_i.push) entry_r[wr_ptr_r] <= push_i.item;
  end

  assign head           = entry_r[rd_ptr_r];
  assign qstat.level    = count_r;
  assign qstat.nonempty = (count_r != '0);

endmodule

### design/spc_back.sv
// Back end: degree and kind of the centre pixel, output register.
module spc_back import spc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  spc_item_t              head,
  input  spc_qstat_t             qstat,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  localparam int PAD_W = OUT_TDATA_W - (2 * POS_W + 1 + DEG_W);

  // Ring count minus adjacent ring pairs
  logic [8:0]        ring;
  logic [3:0]        cnt, pairs, deg4;
  logic              centre;
  logic [DEG_W-1:0]  deg;
  logic [KIND_W-1:0] kind;

  always_comb begin
    centre = head.win[4];
    ring   = head.win & ~WIN_CENTRE;
    cnt    = '0;
    for (int i = 0; i < 9; i++) cnt = cnt + 4'(ring[i]);
    pairs = 4'(ring[0] & ring[3]) + 4'(ring[3] & ring[6]) +
            4'(ring[2] & ring[5]) + 4'(ring[5] & ring[8]) +
            4'(ring[0] & ring[1]) + 4'(ring[1] & ring[2]) +
            4'(ring[6] & ring[7]) + 4'(ring[7] & ring[8]);
    deg4  = (cnt >= pairs) ? cnt - pairs : 4'd0;
    deg   = '0;
    kind  = KIND_NONE;
    if (centre) begin
      deg = DEG_W'(deg4);
      if (deg4 > 4'd2)       kind = KIND_JUNCTION;
      else if (deg4 == 4'd1) kind = KIND_ENDPOINT;
    end
  end

  // Output register
  logic                   valid_r;
  logic [OUT_TDATA_W-1:0] data_r;
  logic [OUT_TUSER_W-1:0] user_r;

  assign pop = qstat.nonempty && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.valid) begin
        data_r <= {PAD_W'(0), deg, centre, head.col, head.row};
        user_r <= {kind, 1'b1};
      end else begin
        data_r <= '0;
        user_r <= '0;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

### design/skeleton_pixel_classifier.sv
// Top level of the skeleton pixel classifier.
//
// A binary skeleton frame enters on the in_ stream in raster order, one pixel
// per transaction (in_tdata[0]). After each frame the source sends
// image_width+1 flush transactions. Every input transaction yields exactly
// one result transaction on the out_ stream, describing the centre pixel one
// row plus one pixel behind; out_tuser[0] flags whether that centre lies in
// the frame, out_tuser[2:1] gives its kind (ordinary, endpoint, junction).
// Pixels outside the frame count as background.
// Throughput is one pixel per cycle while in_tready is high; a result passes
// stage 1 and the queue into the output register. The line stores take one
// read-modify-write per pixel, a read and a registered write-back with a
// bypass. After reset the block sweeps the line stores to zero, one column
// per cycle, with in_tready low; configuration writes are taken meanwhile.
// When the receiver stalls, up to five results collect, four in the queue
// and one in the output register, then in_tready drops. The user writes frame
// size through cfg_we/cfg_addr/cfg_wdata while idle; the block does not check.
module skeleton_pixel_classifier import spc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] pixel_on
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [10:0] out_row, [21:11] out_col,
                                             // [22] centre_on, [25:23] degree
  output logic [OUT_TUSER_W-1:0] out_tuser   // [0] out_valid, [2:1] kind
);

  spc_push_t  push;
  spc_qstat_t qstat;
  spc_item_t  head;
  logic       pop;

  spc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_pixel  (in_tdata[0]),
    .qstat     (qstat),
    .push_o    (push)
  );

  spc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop    (pop),
    .head   (head),
    .qstat  (qstat)
  );

  spc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### dv/skeleton_pixel_classifier_test.sv
// Self-checking stream testbench for the skeleton pixel classifier.
`timescale 1ns / 1ps

module skeleton_pixel_classifier_test;
  import spc_pkg::*;

  localparam int CYCLE_LIMIT   = 600_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PIXELS = 1000;
  localparam int MAX_SHOWN     = 20;
  localparam int DIR_ROWS      = 24;

  // One classified centre pixel, unpacked from the out_ stream
  typedef struct packed {
    logic              valid;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              centre;
    logic [DEG_W-1:0]  degree;
    logic [KIND_W-1:0] kind;
  } px_result_t;

  // Directed stimulus row: a register write or a pixel, optionally with a typed result
  typedef struct packed {
    logic              is_cfg;
    logic [CFG_AW-1:0] addr;
    logic [CFG_W-1:0]  val;
    logic              pix;
    logic              typed;
    px_result_t        want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  skeleton_pixel_classifier u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [0] pixel_on
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [10:0] out_row, [21:11] out_col, [22] centre_on, [25:23] degree
    .out_tuser  (out_tuser)    // [0] out_valid, [2:1] kind
  );

  always #5 clk = ~clk;

  // Shadow copy of the classifier state
  logic             upper_line [DEF_MAX_WIDTH];
  logic             middle_line[DEF_MAX_WIDTH];
  logic [8:0]       window_q = '0;
  int               row_cnt = 0;
  int               col_cnt = 0;
  logic [CFG_W-1:0] width_reg = RST_IMAGE_WIDTH;
  logic [CFG_W-1:0] height_reg = RST_IMAGE_HEIGHT;

  px_result_t pending_results[$];
  bit         calm = 1'b0;
  int         cycle_count = 0;
  int         mismatch_count = 0;
  int         pixels_in = 0;
  int         results_out = 0;
  int         endpoints_seen = 0;
  int         junctions_seen = 0;
  px_result_t got_res;
  px_result_t want_res;

  initial begin
    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      upper_line[i]  = 1'b0;
      middle_line[i] = 1'b0;
    end
  end

  // Shift one pixel into the shadow window and classify the centre it completes
  function automatic px_result_t classify_pixel(input logic pix_in);
    int         w, h, row, col, crow, ccol, cnt, pairs, deg;
    logic       pix, up, mid, centre;
    logic [8:0] nw, m;
    px_result_t res;
    w = (width_reg < 3) ? 3 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
    h = (height_reg < 3) ? 3 : (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT
                                                              : int'(height_reg);
    row = row_cnt;
    col = col_cnt;
    if (col >= w) col = 0;  // width shrank under a running frame
    col = col & (DEF_MAX_WIDTH - 1);
    pix = (row < h) ? pix_in : 1'b0;  // flush rows carry background

    up  = upper_line[col];
    mid = middle_line[col];
    upper_line[col]  = mid;
    middle_line[col] = pix;

    nw = '0;
    for (int r = 0; r < 3; r++) begin
      nw[r*3]   = window_q[r*3+1];
      nw[r*3+1] = window_q[r*3+2];
    end
    nw[2] = up;
    nw[5] = mid;
    nw[8] = pix;
    window_q = nw;

    if (col >= 1) begin
      crow = row - 1;
      ccol = col - 1;
    end else begin
      crow = row - 2;
      ccol = w - 1;
    end

    res = '0;
    if (crow >= 0 && crow < h && ccol >= 0 && ccol < w) begin
      m = window_q;
      if (crow == 0) m = m & ~WIN_TOP;
      if (crow == h - 1) m = m & ~WIN_BOTTOM;
      if (ccol == 0) m = m & ~WIN_LEFT;
      if (ccol == w - 1) m = m & ~WIN_RIGHT;
      centre = m[4];
      m = m & ~WIN_CENTRE;
      cnt = 0;
      pairs = 0;
      deg = 0;
      res.kind = KIND_NONE;
      if (centre) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            if (m[r*3+c]) begin
              cnt++;
              if (r >= 1 && m[(r-1)*3+c]) pairs++;
              if (c >= 1 && m[r*3+c-1]) pairs++;
            end
          end
        end
        deg = (cnt >= pairs) ? cnt - pairs : 0;
        if (deg > 2) res.kind = KIND_JUNCTION;
        else if (deg == 1) res.kind = KIND_ENDPOINT;
      end
      res.valid  = 1'b1;
      res.row    = crow[POS_W-1:0];
      res.col    = ccol[POS_W-1:0];
      res.centre = centre;
      res.degree = deg[DEG_W-1:0];
    end

    // Raster counters; the row after the last flush row restarts the frame
    if (row >= h + 1) begin
      row_cnt = 0;
      col_cnt = 0;
    end else begin
      col++;
      if (col >= w) begin
        col = 0;
        row++;
      end
      col_cnt = col;
      row_cnt = row;
    end
    return res;
  endfunction

  function automatic dir_row_t pix_row(input logic p, input logic typed, input px_result_t want);
    dir_row_t d;
    d = '0;
    d.pix   = p;
    d.typed = typed;
    d.want  = want;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] val);
    dir_row_t d;
    d = '0;
    d.is_cfg = 1'b1;
    d.addr   = addr;
    d.val    = val;
    return d;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN)
      $display("mismatch at result %0d: %0s got %0d expected %0d", results_out, what, got, want);
  endtask

  // Drain all pending results, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    cfg_we    <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Chained writes keep cfg_we high; the next pixel or idle wait lowers it
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    if (addr == REG_IMAGE_WIDTH) width_reg = val;
    else if (addr == REG_IMAGE_HEIGHT) height_reg = val;
  endtask

  // Send one pixel transaction; record the typed or predicted result on acceptance
  task automatic push_pixel(input logic pix, input logic typed, input px_result_t want);
    px_result_t pred;
    cfg_we <= 1'b0;
    while (!calm && ($urandom_range(0, 99) < 12)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-1){1'b0}}, pix};
    do @(posedge clk); while (!in_tready);
    pred = classify_pixel(pix);
    pending_results.insert(pending_results.size(), typed ? want : pred);
    pixels_in++;
  endtask

  // Receiver: random backpressure and result checking
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 12);
    if (rst_n && out_tvalid && out_tready) begin
      got_res.valid  = out_tuser[0];
      got_res.kind   = out_tuser[KIND_W:1];
      got_res.row    = out_tdata[POS_W-1:0];
      got_res.col    = out_tdata[2*POS_W-1:POS_W];
      got_res.centre = out_tdata[2*POS_W];
      got_res.degree = out_tdata[2*POS_W+DEG_W:2*POS_W+1];
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, valid", got_res.valid, 0);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.valid !== want_res.valid)
          report_mismatch("out_valid", got_res.valid, want_res.valid);
        if (got_res.row !== want_res.row) report_mismatch("out_row", got_res.row, want_res.row);
        if (got_res.col !== want_res.col) report_mismatch("out_col", got_res.col, want_res.col);
        if (got_res.centre !== want_res.centre)
          report_mismatch("centre_on", got_res.centre, want_res.centre);
        if (got_res.degree !== want_res.degree)
          report_mismatch("degree", got_res.degree, want_res.degree);
        if (got_res.kind !== want_res.kind) report_mismatch("kind", got_res.kind, want_res.kind);
      end
      if (got_res.kind == KIND_ENDPOINT) endpoints_seen++;
      if (got_res.kind == KIND_JUNCTION) junctions_seen++;
      results_out++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    dir_row_t         dir_tab[DIR_ROWS];
    px_result_t       junction_mid;
    logic [CFG_W-1:0] wv, hv;
    int               w_eff, h_eff, len, n, density, phase, rand_pixels;
    bit               big, cut;

    junction_mid = '{valid: 1'b1, row: 11'd1, col: 11'd1, centre: 1'b1, degree: 3'd4,
                     kind: KIND_JUNCTION};

    // First row at the reset size: no centre yet
    dir_tab[0]  = pix_row(1'b1, 1'b1, '0);
    dir_tab[1]  = pix_row(1'b1, 1'b1, '0);
    dir_tab[2]  = pix_row(1'b0, 1'b1, '0);
    dir_tab[3]  = pix_row(1'b1, 1'b1, '0);
    // Shrink mid-frame to below the minimum, so both clamp to 3x3
    dir_tab[4]  = cfg_row(REG_IMAGE_WIDTH, 12'd1);
    dir_tab[5]  = cfg_row(REG_IMAGE_HEIGHT, 12'd0);
    // Plus shape: four endpoints on the border and a junction in the middle
    dir_tab[6]  = pix_row(1'b0, 1'b1, '0);
    dir_tab[7]  = pix_row(1'b1, 1'b1, '0);
    dir_tab[8]  = pix_row(1'b0, 1'b1, '0);
    dir_tab[9]  = pix_row(1'b1, 1'b1, '0);
    dir_tab[10] = pix_row(1'b1, 1'b0, '0);
    dir_tab[11] = pix_row(1'b1, 1'b0, '0);
    dir_tab[12] = pix_row(1'b0, 1'b0, '0);
    dir_tab[13] = pix_row(1'b1, 1'b0, '0);
    dir_tab[14] = pix_row(1'b0, 1'b1, junction_mid);
    // Flush: set pixels must be ignored
    dir_tab[15] = pix_row(1'b1, 1'b0, '0);
    dir_tab[16] = pix_row(1'b0, 1'b0, '0);
    dir_tab[17] = pix_row(1'b1, 1'b0, '0);
    dir_tab[18] = pix_row(1'b1, 1'b0, '0);
    // Oversized width clamps to the maximum
    dir_tab[19] = cfg_row(REG_IMAGE_WIDTH, 12'hFFF);
    dir_tab[20] = cfg_row(REG_IMAGE_HEIGHT, 12'd3);
    dir_tab[21] = pix_row(1'b1, 1'b1, '0);
    dir_tab[22] = pix_row(1'b1, 1'b1, '0);
    dir_tab[23] = pix_row(1'b1, 1'b1, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].is_cfg) begin
        wait_idle();
        write_reg(dir_tab[i].addr, dir_tab[i].val);
      end else begin
        push_pixel(dir_tab[i].pix, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Random frames: mostly small, two at the largest width or height (only their top part), some cut short
    phase = 0;
    rand_pixels = 0;
    while (rand_pixels < RANDOM_PIXELS) begin
      phase++;
      big = (phase == 5) || (phase == 9);
      if (phase == 5) begin
        wv = 12'd2048;
        hv = CFG_W'($urandom_range(0, 3));
      end else if (phase == 9) begin
        wv = 12'd3;
        hv = 12'hFFF;
      end else begin
        wv = CFG_W'($urandom_range(3, 12));
        hv = CFG_W'($urandom_range(3, 10));
        case ($urandom_range(0, 9))
          0: wv = CFG_W'($urandom_range(0, 2));
          1: hv = CFG_W'($urandom_range(0, 2));
          default: ;
        endcase
      end
      w_eff = (wv < 3) ? 3 : (wv > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(wv);
      h_eff = (hv < 3) ? 3 : (hv > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(hv);
      len = w_eff * h_eff + w_eff + 1;
      cut = !big && ($urandom_range(0, 99) < 15);
      if (big) n = $urandom_range(100, 200);
      else     n = cut ? $urandom_range(1, len - 1) : len;
      density = $urandom_range(5, 75);

      wait_idle();
      if ($urandom_range(0, 1)) begin
        write_reg(REG_IMAGE_WIDTH, wv);
        write_reg(REG_IMAGE_HEIGHT, hv);
      end else begin
        write_reg(REG_IMAGE_HEIGHT, hv);
        write_reg(REG_IMAGE_WIDTH, wv);
      end
      calm = big || (phase % 6 == 2);
      repeat (n) push_pixel($urandom_range(0, 99) < density, 1'b0, '0);
      rand_pixels += n;
    end

    calm = 1'b0;
    wait_idle();

    $display("ran %0d random phases after the directed rows: %0d pixels in, %0d results out",
             phase, pixels_in, results_out);
    $display("saw %0d endpoints and %0d junctions; size registers from below 3 up to 4095",
             endpoints_seen, junctions_seen);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### skeleton_pixel_classifier.f
design/spc_pkg.sv
design/spc_front.sv
design/spc_queue.sv
design/spc_back.sv
design/skeleton_pixel_classifier.sv
dv/skeleton_pixel_classifier_test.sv
